[design/swsc_pkg.sv]
// Shared types and constants for the sorted wakeup source counter.
`timescale 1ns / 1ps

package swsc_pkg;

    localparam int ADDR_W = 32;
    localparam int UID_W  = 18;
    localparam int CNT_W  = 14;
    localparam int ENTRY_W = ADDR_W + UID_W + CNT_W;

    // Input word: source_address, user_id, padded to whole bytes.
    localparam int S_DATA_W = ((ADDR_W + UID_W + 7) / 8) * 8;
    // Output word: out_address, out_user_id, out_count.
    localparam int M_DATA_W = ((ENTRY_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    localparam int TABLE_ENTRIES_DEF  = 128;
    localparam int REPORT_ENTRIES_DEF = 5;

    localparam logic MODE_WAKEUP = 1'b0;
    localparam logic MODE_REPORT = 1'b1;

    // One table entry, address in the lowest bits.
    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [UID_W-1:0]  uid;
        logic [ADDR_W-1:0] addr;
    } entry_t;

endpackage

[design/swsc_table.sv]
// Source table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module swsc_table #(
    parameter int TABLE_ENTRIES = swsc_pkg::TABLE_ENTRIES_DEF,
    parameter int IDX_W = $clog2(TABLE_ENTRIES)
) (
    input  logic                aclk,
    input  logic [IDX_W-1:0]    rd_addr,
    output swsc_pkg::entry_t    rd_data,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  swsc_pkg::entry_t    wr_data
);
    import swsc_pkg::*;

    entry_t mem [TABLE_ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[design/sorted_wakeup_source_counter.sv]
// Top level of the sorted wakeup source counter.
`timescale 1ns / 1ps

// Counts wakeup events per source address in a table of TABLE_ENTRIES
// entries (address, user id, 14-bit saturating count) kept in descending
// count order, ties in arrival order. A word with tuser = 0 is a wakeup:
// the table is scanned from the top, one entry a cycle through the single
// read port of the table memory. A hit bumps the count and moves the entry
// above its run of equal counts by shifting that run down one slot (one
// entry a cycle); a miss appends the source with count 1, or replaces the
// bottom entry when the table is full. A word with tuser = 1 emits the top
// REPORT_ENTRIES entries (empty slots as all zero, tlast on the final word),
// each read from the table and then loaded into the output register once
// that register is free or being taken, then empties the table. Occupancy
// is a fill count, so there is no clearing pass after reset or report.
// s_tready is high only while no word is in work; the output register lets
// the block finish while a result waits.
module sorted_wakeup_source_counter #(
    parameter int TABLE_ENTRIES  = swsc_pkg::TABLE_ENTRIES_DEF,
    parameter int REPORT_ENTRIES = swsc_pkg::REPORT_ENTRIES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [31:0] source_address, [49:32] user_id, [55:50] zero
    input  logic [swsc_pkg::S_DATA_W-1:0] s_tdata,
    // [0] mode
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] out_address, [49:32] out_user_id, [63:50] out_count
    output logic [swsc_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import swsc_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
    localparam int RPT_W = (REPORT_ENTRIES > 1) ? $clog2(REPORT_ENTRIES) : 1;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_SHIFT   = 3'd2;
    localparam logic [2:0] S_PLACE   = 3'd3;
    localparam logic [2:0] S_RPT_RD  = 3'd4;
    localparam logic [2:0] S_RPT_OUT = 3'd5;

    // Control state
    logic [2:0]        state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] scan_idx_reg, scan_idx_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic              sh_issue_reg, sh_issue_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [RPT_W-1:0]  rpt_idx_reg, rpt_idx_next;
    logic              m_valid_reg, m_valid_next;

    // Payload
    logic [ADDR_W-1:0] key_addr_reg, key_addr_next;
    logic [UID_W-1:0]  key_uid_reg, key_uid_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]  run_start_reg, run_start_next;
    logic [CNT_W-1:0]  prev_cnt_reg, prev_cnt_next;
    entry_t            hit_ent_reg, hit_ent_next;
    logic [IDX_W-1:0]  place_idx_reg, place_idx_next;
    logic [IDX_W-1:0]  sh_rd_reg, sh_rd_next;
    logic [IDX_W-1:0]  sh_lo_reg, sh_lo_next;
    logic [IDX_W-1:0]  wr_idx_reg, wr_idx_next;
    entry_t            out_ent_reg, out_ent_next;
    logic              out_last_reg, out_last_next;

    // Table ports
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    logic             s_accept;
    logic             out_load;
    logic             rpt_last;
    logic             rpt_occupied;
    logic [IDX_W-1:0] run_lo;

    swsc_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .IDX_W        (IDX_W)
    ) u_table (
        .aclk   (aclk),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'(out_ent_reg);
    assign m_tlast  = out_last_reg;

    // Start of the run of equal counts that holds the entry under compare
    assign run_lo = ((cmp_idx_reg == '0) || (rd_data.cnt != prev_cnt_reg))
                    ? cmp_idx_reg : run_start_reg;

    assign rpt_last     = (rpt_idx_reg == RPT_W'(REPORT_ENTRIES - 1));
    assign rpt_occupied = (32'(rpt_idx_reg) < 32'(fill_reg));
    assign out_load     = (state_reg == S_RPT_OUT) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_vld_next   = 1'b0;
        sh_issue_next  = sh_issue_reg;
        wr_pend_next   = 1'b0;
        rpt_idx_next   = rpt_idx_reg;
        key_addr_next  = key_addr_reg;
        key_uid_next   = key_uid_reg;
        cmp_idx_next   = cmp_idx_reg;
        run_start_next = run_start_reg;
        prev_cnt_next  = prev_cnt_reg;
        hit_ent_next   = hit_ent_reg;
        place_idx_next = place_idx_reg;
        sh_rd_next     = sh_rd_reg;
        sh_lo_next     = sh_lo_reg;
        wr_idx_next    = wr_idx_reg;
        out_ent_next   = out_ent_reg;
        out_last_next  = out_last_reg;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    key_addr_next = s_tdata[ADDR_W-1:0];
                    key_uid_next  = s_tdata[ADDR_W +: UID_W];
                    scan_idx_next = '0;
                    rpt_idx_next  = '0;
                    state_next    = (s_tuser[0] == MODE_REPORT) ? S_RPT_RD : S_SCAN;
                end
            end

            S_SCAN: begin
                // Issue the next read while the previous word is compared
                rd_addr = IDX_W'(scan_idx_reg);
                if (scan_idx_reg < fill_reg) begin
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = IDX_W'(scan_idx_reg);
                    scan_idx_next = scan_idx_reg + FILL_W'(1);
                end
                if (cmp_vld_reg) begin
                    run_start_next = run_lo;
                    prev_cnt_next  = rd_data.cnt;
                    if (rd_data.addr == key_addr_reg) begin
                        cmp_vld_next     = 1'b0;
                        hit_ent_next     = rd_data;
                        hit_ent_next.cnt = rd_data.cnt + CNT_W'(1);
                        place_idx_next   = run_lo;
                        sh_lo_next       = run_lo;
                        sh_rd_next       = cmp_idx_reg - IDX_W'(1);
                        sh_issue_next    = 1'b1;
                        priority if (rd_data.cnt == COUNT_MAX) begin
                            state_next = S_IDLE;
                        end else if (run_lo == cmp_idx_reg) begin
                            state_next = S_PLACE;
                        end else begin
                            state_next = S_SHIFT;
                        end
                    end
                end else if (!(scan_idx_reg < fill_reg)) begin
                    // Miss: append, or replace the bottom entry when full
                    wr_en        = 1'b1;
                    wr_data.addr = key_addr_reg;
                    wr_data.uid  = key_uid_reg;
                    wr_data.cnt  = CNT_W'(1);
                    if (32'(fill_reg) < TABLE_ENTRIES) begin
                        wr_addr   = IDX_W'(fill_reg);
                        fill_next = fill_reg + FILL_W'(1);
                    end else begin
                        wr_addr = IDX_W'(TABLE_ENTRIES - 1);
                    end
                    state_next = S_IDLE;
                end
            end

            S_SHIFT: begin
                // Move the run of equal counts down one slot, bottom first
                rd_addr = sh_rd_reg;
                if (sh_issue_reg) begin
                    wr_pend_next = 1'b1;
                    wr_idx_next  = sh_rd_reg + IDX_W'(1);
                    if (sh_rd_reg == sh_lo_reg) begin
                        sh_issue_next = 1'b0;
                    end else begin
                        sh_rd_next = sh_rd_reg - IDX_W'(1);
                    end
                end else begin
                    state_next = S_PLACE;
                end
                if (wr_pend_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = wr_idx_reg;
                    wr_data = rd_data;
                end
            end

            S_PLACE: begin
                wr_en      = 1'b1;
                wr_addr    = place_idx_reg;
                wr_data    = hit_ent_reg;
                state_next = S_IDLE;
            end

            S_RPT_RD: begin
                rd_addr    = IDX_W'(rpt_idx_reg);
                state_next = S_RPT_OUT;
            end

            S_RPT_OUT: begin
                rd_addr = IDX_W'(rpt_idx_reg);
                if (out_load) begin
                    out_ent_next  = rpt_occupied ? rd_data : '0;
                    out_last_next = rpt_last;
                    if (rpt_last) begin
                        fill_next  = '0;
                        state_next = S_IDLE;
                    end else begin
                        rpt_idx_next = rpt_idx_reg + RPT_W'(1);
                        state_next   = S_RPT_RD;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: load a report word, drop it once taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            sh_issue_reg <= 1'b0;
            wr_pend_reg  <= 1'b0;
            rpt_idx_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            scan_idx_reg <= scan_idx_next;
            cmp_vld_reg  <= cmp_vld_next;
            sh_issue_reg <= sh_issue_next;
            wr_pend_reg  <= wr_pend_next;
            rpt_idx_reg  <= rpt_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_addr_reg  <= key_addr_next;
        key_uid_reg   <= key_uid_next;
        cmp_idx_reg   <= cmp_idx_next;
        run_start_reg <= run_start_next;
        prev_cnt_reg  <= prev_cnt_next;
        hit_ent_reg   <= hit_ent_next;
        place_idx_reg <= place_idx_next;
        sh_rd_reg     <= sh_rd_next;
        sh_lo_reg     <= sh_lo_next;
        wr_idx_reg    <= wr_idx_next;
        out_ent_reg   <= out_ent_next;
        out_last_reg  <= out_last_next;
    end

`ifndef ASSERT_OFF
    // Fill count never passes the table size
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(fill_reg) <= TABLE_ENTRIES)
        else $error("fill count beyond table size");

    // A report never writes the table
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RPT_RD || state_reg == S_RPT_OUT) |-> !wr_en)
        else $error("table write during report");

    // Loading the final report word empties the table
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && rpt_last) |=> (fill_reg == '0 && m_tlast && m_tvalid))
        else $error("table not emptied after report");

    // Every compared entry lies inside the occupied region
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_vld_reg |-> (32'(cmp_idx_reg) < 32'(fill_reg)))
        else $error("compare outside occupied entries");
`endif

endmodule
